// File: rtl/ind_pkg.sv
package ind_pkg;

    localparam int NODE_W        = 10;
    localparam int COORD_W       = 24;
    localparam int DIST_W        = 17;
    localparam int MODE_W        = 2;
    localparam int MAX_NODES_DEF = 1024;
    localparam int FRAC_BITS_DEF = 8;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [MODE_W-1:0] MODE_ROUND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CEIL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ATT   = 2'd2;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // one query with both endpoints fetched
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [COORD_W-1:0] xa;
        logic signed [COORD_W-1:0] ya;
        logic signed [COORD_W-1:0] xb;
        logic signed [COORD_W-1:0] yb;
    } t_pair;

endpackage

// File: rtl/ind_front.sv
module ind_front #(
    parameter int MAX_NODES = ind_pkg::MAX_NODES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic                               i_opcode,
    input  logic [ind_pkg::NODE_W-1:0]         i_node_a,
    input  logic [ind_pkg::NODE_W-1:0]         i_node_b,
    input  logic signed [ind_pkg::COORD_W-1:0] i_x_coord,
    input  logic signed [ind_pkg::COORD_W-1:0] i_y_coord,
    input  logic [ind_pkg::MODE_W-1:0]         i_mode,
    output logic                               o_valid,
    output ind_pkg::t_pair                     o_pair
);
    import ind_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EW = ((AW > NODE_W) ? AW : NODE_W) + 1;

    logic [2*COORD_W-1:0] r_mem [0:MAX_NODES-1];
    logic [2*COORD_W-1:0] r_rd_a, r_rd_b;
    logic                 r_in_a, r_in_b, r_valid;
    logic [MODE_W-1:0]    r_mode;
    logic [EW-1:0]        ext_a, ext_b;
    logic                 in_a, in_b;

    assign ext_a = EW'(i_node_a);
    assign ext_b = EW'(i_node_b);
    assign in_a  = ext_a < EW'(MAX_NODES);
    assign in_b  = ext_b < EW'(MAX_NODES);

    always_ff @(posedge i_clk) begin
        if (i_accept && i_opcode == OP_STORE && in_a) begin
            r_mem[ext_a[AW-1:0]] <= {i_x_coord, i_y_coord};
        end
        r_rd_a <= r_mem[ext_a[AW-1:0]];
        r_rd_b <= r_mem[ext_b[AW-1:0]];
        r_in_a <= in_a;
        r_in_b <= in_b;
        r_mode <= i_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept && i_opcode == OP_QUERY;
        end
    end

    // nodes beyond the table read as the origin
    assign o_valid     = r_valid;
    assign o_pair.mode = r_mode;
    assign o_pair.xa   = r_in_a ? r_rd_a[2*COORD_W-1:COORD_W] : '0;
    assign o_pair.ya   = r_in_a ? r_rd_a[COORD_W-1:0] : '0;
    assign o_pair.xb   = r_in_b ? r_rd_b[2*COORD_W-1:COORD_W] : '0;
    assign o_pair.yb   = r_in_b ? r_rd_b[COORD_W-1:0] : '0;

endmodule

// File: rtl/ind_queue.sv
module ind_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ind_pkg::t_pair i_pair,
    output logic           o_valid,
    output ind_pkg::t_pair o_pair,
    output logic           o_almost_full
);
    import ind_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_pair          r_mem [0:QUEUE_DEPTH-1];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    logic           pop;

    // the back end never stalls, so the head leaves as soon as it is there
    assign pop           = r_cnt != '0;
    assign o_valid       = pop;
    assign o_pair        = r_mem[r_rp];
    assign o_almost_full = r_cnt >= CW'(QUEUE_DEPTH - 1);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (pop)    r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + CW'(i_push) - CW'(pop);
        end
    end

endmodule

// File: rtl/ind_back.sv
module ind_back #(
    parameter int FRAC_BITS = ind_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  ind_pkg::t_pair             i_pair,
    output logic                       o_valid,
    output logic [ind_pkg::DIST_W-1:0] o_distance
);
    import ind_pkg::*;

    localparam int DW = COORD_W + 1;
    localparam int QW = 2 * DW;
    localparam int SW = QW + 1;
    localparam int LW = SW + 2;
    localparam int SH = 2 * FRAC_BITS;
    localparam int NS = DIST_W;

    // stage a: absolute differences
    logic              r_va;
    logic [MODE_W-1:0] r_ma;
    logic [DW-1:0]     r_dx, r_dy;
    logic signed [DW-1:0] ddx, ddy;

    assign ddx = DW'(i_pair.xa) - DW'(i_pair.xb);
    assign ddy = DW'(i_pair.ya) - DW'(i_pair.yb);

    // stage b: squares, stage c: sum, stage d: search limit
    logic              r_vb, r_vc, r_vd;
    logic [MODE_W-1:0] r_mb, r_mc, r_md;
    logic [QW-1:0]     r_sx, r_sy;
    logic [SW-1:0]     r_s;
    logic [LW-1:0]     r_l;
    logic              r_z;
    logic [LW-1:0]     lim_round, t_ceil;

    assign lim_round = ({r_s, 2'b00}) >> SH;
    assign t_ceil    = (LW'(r_s) + LW'((64'd1 << SH) - 64'd1)) >> SH;

    always_ff @(posedge i_clk) begin
        r_ma <= i_pair.mode;
        r_dx <= ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
        r_dy <= ddy[DW-1] ? DW'(-ddy) : DW'(ddy);
        r_mb <= r_ma;
        r_sx <= r_dx * r_dx;
        r_sy <= r_dy * r_dy;
        r_mc <= r_mb;
        r_s  <= SW'(r_sx) + SW'(r_sy);
        r_md <= r_mc;
        r_z  <= r_s == '0;
        r_l  <= (r_mc == MODE_CEIL || r_mc == MODE_ATT) ? t_ceil - 1'b1 : lim_round;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    // bit-by-bit search for the largest result k that passes its mode's test
    logic              r_sv [0:NS];
    logic [MODE_W-1:0] r_sm [0:NS];
    logic [LW-1:0]     r_sl [0:NS];
    logic              r_sz [0:NS];
    logic [DIST_W-1:0] r_sr [0:NS];

    always_comb begin
        r_sv[0] = r_vd;
        r_sm[0] = r_md;
        r_sl[0] = r_l;
        r_sz[0] = r_z;
        r_sr[0] = '0;
    end

    for (genvar j = 0; j < NS; j++) begin : g_step
        logic [DIST_W-1:0] cand;
        logic [DIST_W:0]   v;
        logic [2*DIST_W+1:0] p;
        logic [2*DIST_W+5:0] pm;
        logic              ok, ceil_mode;

        assign cand      = r_sr[j] | (DIST_W'(1) << (NS - 1 - j));
        assign ceil_mode = r_sm[j] == MODE_CEIL || r_sm[j] == MODE_ATT;
        assign v         = ceil_mode ? ({1'b0, cand} - 1'b1) : ({cand, 1'b0} - 1'b1);
        assign p         = v * v;
        assign pm        = (r_sm[j] == MODE_ATT) ? (($bits(pm))'(p) << 3) + (($bits(pm))'(p) << 1)
                                                 : ($bits(pm))'(p);
        assign ok        = !(ceil_mode && r_sz[j]) && (LW'(pm) <= r_sl[j]);

        always_ff @(posedge i_clk) begin
            r_sm[j+1] <= r_sm[j];
            r_sl[j+1] <= r_sl[j];
            r_sz[j+1] <= r_sz[j];
            r_sr[j+1] <= ok ? cand : r_sr[j];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j+1] <= 1'b0;
            end else begin
                r_sv[j+1] <= r_sv[j];
            end
        end
    end

    assign o_valid    = r_sv[NS];
    assign o_distance = r_sr[NS];

endmodule

// File: rtl/integer_node_distance.sv
// a query's endpoints are read, queued and then measured; a store gives no result
// throughput: one item per cycle while o_busy is low; the coordinate table has two read
// ports and one write port and the distance pipeline takes a new query every cycle
// reset: clears the mode register to rounded euclidean and all valid flags; the coordinate
// table is not cleared and must be written before it is queried; results cannot be stalled
module integer_node_distance #(
    parameter int MAX_NODES = ind_pkg::MAX_NODES_DEF,
    parameter int FRAC_BITS = ind_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic                               i_opcode,
    input  logic [ind_pkg::NODE_W-1:0]         i_node_a,
    input  logic [ind_pkg::NODE_W-1:0]         i_node_b,
    input  logic signed [ind_pkg::COORD_W-1:0] i_x_coord,
    input  logic signed [ind_pkg::COORD_W-1:0] i_y_coord,
    input  logic                               i_cfg_we,
    input  logic [ind_pkg::MODE_W-1:0]         i_cfg_wdata,
    output logic                               o_valid,
    output logic [ind_pkg::DIST_W-1:0]         o_distance
);
    import ind_pkg::*;

    logic [MODE_W-1:0] r_mode;
    logic              accept, f_valid, q_valid, q_afull;
    t_pair             f_pair, q_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ROUND;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    assign o_busy = q_afull;
    assign accept = i_start && !o_busy;

    ind_front #(.MAX_NODES(MAX_NODES)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_opcode  (i_opcode),
        .i_node_a  (i_node_a),
        .i_node_b  (i_node_b),
        .i_x_coord (i_x_coord),
        .i_y_coord (i_y_coord),
        .i_mode    (r_mode),
        .o_valid   (f_valid),
        .o_pair    (f_pair)
    );

    ind_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (f_valid),
        .i_pair        (f_pair),
        .o_valid       (q_valid),
        .o_pair        (q_pair),
        .o_almost_full (q_afull)
    );

    ind_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_pair     (q_pair),
        .o_valid    (o_valid),
        .o_distance (o_distance)
    );

endmodule

// File: sim/integer_node_distance_test.sv
module integer_node_distance_test;
    import ind_pkg::*;

    localparam int LATENCY = 23;
    localparam logic [DIST_W-1:0] DIST_SAT = '1;
    // the unused mode code, which behaves as rounded euclidean
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    class distance_scoreboard;
        logic [DIST_W-1:0] pending[$];
        int checked;

        function void note_query(logic [DIST_W-1:0] d);
            pending.push_back(d);
        endfunction

        // returns 0 on mismatch or when no distance was waiting
        function bit check(logic [DIST_W-1:0] got, output logic [DIST_W-1:0] want,
                           output bit orphan);
            orphan = (pending.size() == 0);
            want = '0;
            if (orphan) return 0;
            want = pending.pop_front();
            checked++;
            return want == got;
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_start = 1'b0;
    logic                      o_busy;
    logic                      i_opcode = OP_STORE;
    logic [NODE_W-1:0]         i_node_a = '0;
    logic [NODE_W-1:0]         i_node_b = '0;
    logic signed [COORD_W-1:0] i_x_coord = '0;
    logic signed [COORD_W-1:0] i_y_coord = '0;
    logic                      i_cfg_we = 1'b0;
    logic [MODE_W-1:0]         i_cfg_wdata = '0;
    logic                      o_valid;
    logic [DIST_W-1:0]         o_distance;

    integer_node_distance dut (.*);

    always #5 i_clk = ~i_clk;

    distance_scoreboard sb = new();
    int errors = 0;
    int idle_pct = 0;
    int queries = 0;

    // predictor state
    logic [MODE_W-1:0]         cur_mode = MODE_ROUND;
    logic signed [COORD_W-1:0] node_x[1024];
    logic signed [COORD_W-1:0] node_y[1024];
    bit                        node_known[1024];
    logic [NODE_W-1:0]         known_list[$];

    task automatic report(string what);
        $display("mismatch @%0t: %s", $time, what);
        errors++;
    endtask

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned ceil_root(longint unsigned v);
        longint unsigned q = int_sqrt(v);
        return (q * q == v) ? q : q + 1;
    endfunction

    function automatic logic [DIST_W-1:0] predict_distance(logic [NODE_W-1:0] a,
                                                            logic [NODE_W-1:0] b);
        longint signed dx, dy;
        longint unsigned s, n;
        longint unsigned den = 64'd1 << 16;
        dx = longint'(node_x[a]) - longint'(node_x[b]);
        dy = longint'(node_y[a]) - longint'(node_y[b]);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        s = dx * dx + dy * dy;
        case (cur_mode)
            MODE_CEIL: n = ceil_root((s + den - 1) / den);
            MODE_ATT:  n = ceil_root((s + den * 10 - 1) / (den * 10));
            default:   n = (int_sqrt((s * 4) / den) + 1) / 2;
        endcase
        return (n > DIST_SAT) ? DIST_SAT : n[DIST_W-1:0];
    endfunction

    // accepted items update the predicted table, results are checked in order
    always @(posedge i_clk) begin
        logic [DIST_W-1:0] want;
        bit orphan;
        if (i_rst_n && i_start && !o_busy) begin
            if (i_opcode == OP_STORE) begin
                node_x[i_node_a] <= i_x_coord;
                node_y[i_node_a] <= i_y_coord;
            end else begin
                sb.note_query(predict_distance(i_node_a, i_node_b));
                queries++;
            end
        end
        if (i_rst_n && o_valid && !sb.check(o_distance, want, orphan)) begin
            if (orphan) report($sformatf("distance %0d with nothing pending", o_distance));
            else report($sformatf("distance %0d, predicted %0d", o_distance, want));
        end
    end

    task automatic send_item(logic op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                             logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        // each cycle stays idle with the given chance
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_opcode <= op;
        i_node_a <= a;
        i_node_b <= b;
        i_x_coord <= x;
        i_y_coord <= y;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        if (op == OP_STORE && !node_known[a]) begin
            node_known[a] = 1;
            known_list.push_back(a);
        end
    endtask

    task automatic store(logic [NODE_W-1:0] a, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        send_item(OP_STORE, a, NODE_W'($urandom), x, y);
    endtask

    task automatic query(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
        send_item(OP_QUERY, a, b, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic set_mode(logic [MODE_W-1:0] m);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        cur_mode = m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        if ($urandom_range(1)) return COORD_W'($urandom);
        return COORD_W'($signed($urandom_range(4000)) - 2000);
    endfunction

    function automatic logic [NODE_W-1:0] pick_known();
        return known_list[$urandom_range(known_list.size() - 1)];
    endfunction

    initial begin
        logic [MODE_W-1:0] mode_seq[6];
        int r;
        logic [NODE_W-1:0] n;
        mode_seq = '{MODE_CEIL, MODE_ATT, MODE_SPARE, MODE_ROUND, MODE_ATT, MODE_CEIL};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, fractions, same node, then every mode on the same pairs
        store(10'd0, 24'h7FFFFF, 24'h7FFFFF);
        store(10'd1023, 24'h800000, 24'h800000);
        store(10'd1, 24'h000000, 24'h000000);
        store(10'd2, 24'h000180, 24'hFFFF80);
        store(10'd3, 24'h000300, 24'h000400);
        store(10'd682, 24'h800000, 24'h7FFFFF);
        for (int m = 0; m < 4; m++) begin
            if (m != 0) set_mode(m[MODE_W-1:0]);
            query(10'd0, 10'd1023);
            query(10'd1, 10'd2);
            query(10'd1, 10'd3);
            query(10'd682, 10'd682);
        end

        for (int ph = 0; ph < 6; ph++) begin
            idle_pct = (ph < 2) ? 37 : (ph < 4) ? 66 : 0;
            set_mode(mode_seq[ph]);
            for (int k = 0; k < 330; k++) begin
                r = $urandom_range(99);
                if (r < 30 || known_list.size() < 4) begin
                    store(NODE_W'($urandom), rand_coord(), rand_coord());
                end else if (r < 35) begin
                    n = pick_known();
                    query(n, n);
                end else begin
                    query(pick_known(), pick_known());
                end
            end
        end

        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("covered %0d queries over all four mode settings, %0d nodes written",
                 queries, known_list.size());
        $display("checked %0d distances, %0d mismatches", sb.checked, errors);
        if (errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout, %0d distances still pending", sb.pending.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
